### rtl/ppu_vram_mirrored_access_core_assert.svh
// Assertion macros for the video memory access block.
// Used by the top level only; compiled out when SYNTHESIS is defined.
`ifndef PPU_VRAM_MIRRORED_ACCESS_CORE_ASSERT_SVH
`define PPU_VRAM_MIRRORED_ACCESS_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define PVMA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pvma assertion failed");
// Implication checked on the following clock edge.
`define PVMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pvma assertion failed");
`else
`define PVMA_ASSERT(lbl, clk, rstn, prop)
`define PVMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/ppu_vram_pkg.sv
// Shared constants and types for the video memory access block.
// No dependencies.
`timescale 1ns / 1ps

package ppu_vram_pkg;

  localparam int unsigned StoreAddrBits = 16;
  localparam int unsigned StoreDepth    = 1 << StoreAddrBits;

  // command codes
  localparam logic [1:0] CmdRead  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdLoad  = 2'd2;

  // name table mirroring modes
  localparam logic [1:0] MirrorHorz   = 2'd0;
  localparam logic [1:0] MirrorVert   = 2'd1;
  localparam logic [1:0] MirrorSingle = 2'd2;

  // configuration register indices
  localparam logic RegMirrorMode = 1'b0;
  localparam logic RegChrOffset  = 1'b1;

  localparam logic [15:0] NameBase     = 16'h2000;
  localparam logic [15:0] NameHalf     = 16'h2800;
  localparam logic [15:0] NameMaskLo   = 16'h23FF;
  localparam logic [15:0] NameMaskHi   = 16'h2BFF;
  localparam logic [15:0] NameStep     = 16'h0800;
  localparam logic [15:0] NameMirror   = 16'h3000;
  localparam logic [15:0] NameDrop     = 16'h1000;
  localparam logic [15:0] PalBase      = 16'h3F00;
  localparam logic [15:0] PalSprite    = 16'h3F10;
  localparam logic [15:0] PalEnd       = 16'h3F20;
  localparam logic [15:0] PalFoldMask  = 16'h3F1F;
  localparam logic [15:0] PalAlias     = 16'h0010;

  typedef struct packed {
    logic [15:0] phys;
    logic        rd_en;
    logic        wr_en;
  } access_t;

endpackage

### rtl/ppu_vram_decode.sv
// Address folding for the video memory: pattern bank offset, name table
// mirroring and palette aliasing. Depends on ppu_vram_pkg.
`timescale 1ns / 1ps

module ppu_vram_decode import ppu_vram_pkg::*; (
  input  logic [1:0]  mirror_mode_i,
  input  logic [15:0] chr_offset_i,
  input  logic [1:0]  command_i,
  input  logic [15:0] address_i,
  output access_t     access_o
);

  logic [15:0] nt_in;
  logic [15:0] nt_out;
  logic [15:0] pal_in;
  logic [15:0] pal_out;
  logic [15:0] decoded;

  // 0x3000-0x3EFF drops onto the name tables first
  assign nt_in = (address_i < NameMirror) ? address_i : (address_i - NameDrop);

  always_comb begin
    nt_out = nt_in;
    case (mirror_mode_i)
      MirrorHorz:   nt_out = nt_in & ((nt_in < NameHalf) ? NameMaskLo : NameMaskHi);
      MirrorVert:   nt_out = (nt_in >= NameHalf) ? (nt_in - NameStep) : nt_in;
      MirrorSingle: nt_out = nt_in & NameMaskLo;
      default:      nt_out = nt_in;
    endcase
  end

  assign pal_in  = (address_i < PalEnd) ? address_i : (address_i & PalFoldMask);
  // sprite palette entry 0 of each group aliases the background one
  assign pal_out = ((pal_in >= PalSprite) && (pal_in[1:0] == 2'b00)) ?
                   (pal_in - PalAlias) : pal_in;

  always_comb begin
    if (address_i < NameBase) begin
      decoded = address_i + chr_offset_i;
    end else if (address_i < PalBase) begin
      decoded = nt_out;
    end else begin
      decoded = pal_out;
    end
  end

  always_comb begin
    access_o.phys  = address_i;
    access_o.rd_en = 1'b0;
    access_o.wr_en = 1'b0;
    case (command_i)
      CmdRead: begin
        access_o.phys  = decoded;
        access_o.rd_en = 1'b1;
      end
      CmdWrite: begin
        access_o.phys  = decoded;
        access_o.wr_en = (address_i >= NameBase);
      end
      CmdLoad: begin
        access_o.wr_en = 1'b1;
      end
      default: begin
        access_o.phys = address_i;
      end
    endcase
  end

endmodule

### rtl/ppu_vram_mirrored_access_core.sv
// Top level of the video memory access block: config registers, the store
// and the output stage. Depends on ppu_vram_pkg, ppu_vram_decode and
// ppu_vram_mirrored_access_core_assert.svh.
`timescale 1ns / 1ps
`include "ppu_vram_mirrored_access_core_assert.svh"

// Usage
//   Input channel (in_valid_i / in_stall_o) carries one access per beat:
//   command, address and write data. Output channel (out_valid_o /
//   out_stall_i) returns one beat per access: read data (zero unless a
//   read) and the physical address used.
//   Configuration: cfg_we_i with cfg_idx_i 0 sets the mirroring mode,
//   1 the pattern bank offset; write only while the block is idle.
//   Timing: the result is registered and valid in the cycle after the access is accepted.
//   Throughput: one access per cycle while the output is not stalled; the
//   single-port store with its registered read data is the output stage.
//   Stall: while a result is held under out_stall_i, in_stall_o is high and
//   the read data register keeps its value.
//   Reset: clears the config registers and the output valid. The store is
//   not cleared; an entry reads as undefined until it has been written.
module ppu_vram_mirrored_access_core import ppu_vram_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic [15:0] physical_address_o
);

  logic [1:0]  mirror_mode_q;
  logic [15:0] chr_offset_q;
  access_t     access;
  logic        accept;
  logic        mem_we;
  logic        mem_re;
  logic [StoreAddrBits-1:0] mem_addr;
  logic [7:0]  mem_q [StoreDepth];
  logic [7:0]  rdata_q;
  logic        valid_q, valid_d;
  logic        is_read_q;
  logic [15:0] phys_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_mode_q <= MirrorHorz;
      chr_offset_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMirrorMode: mirror_mode_q <= cfg_wdata_i[1:0];
        RegChrOffset:  chr_offset_q  <= cfg_wdata_i;
        default:       mirror_mode_q <= mirror_mode_q;
      endcase
    end
  end

  ppu_vram_decode u_decode (
    .mirror_mode_i (mirror_mode_q),
    .chr_offset_i  (chr_offset_q),
    .command_i     (command_i),
    .address_i     (address_i),
    .access_o      (access)
  );

  assign in_stall_o = valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign mem_we     = accept & access.wr_en;
  assign mem_re     = accept & access.rd_en;
  assign mem_addr   = access.phys[StoreAddrBits-1:0];

  // one access per item, so a read never meets a write in the same cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= write_data_i;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      phys_q    <= access.phys;
      is_read_q <= access.rd_en;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o        = valid_q;
  assign read_data_o        = is_read_q ? rdata_q : 8'd0;
  assign physical_address_o = phys_q;

  `PVMA_ASSERT_NEXT(a_accept_gives_result, clk_i, rst_ni, accept, out_valid_o)
  `PVMA_ASSERT(a_stall_blocks_input, clk_i, rst_ni, !(out_valid_o && out_stall_i) || !accept)
  `PVMA_ASSERT(a_no_pattern_write, clk_i, rst_ni,
               !(mem_we && command_i == CmdWrite) || (address_i >= NameBase))
  `PVMA_ASSERT(a_single_access, clk_i, rst_ni, !(mem_we && mem_re))

endmodule
